// File: hdl/biquad_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared types and constants for the biquad controller and datapath.
// ----------------------------------------------------------------------------
package biquad_pkg;

  // Coefficient and state word widths
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned ST_W      = 56;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Item operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Saturation bounds of the state words
  localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

  // Datapath commands, one per cycle
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LOAD  = 3'd1,  // latch sample, multiply by b0
    CMD_CLEAR = 3'd2,  // zero both states
    CMD_ROUND = 3'd3,  // form output, multiply x by b1
    CMD_SUM1  = 3'd4,  // x*b1 + delay two, multiply y by a1
    CMD_UPD1  = 3'd5,  // write delay one, multiply x by b2
    CMD_SUM2  = 3'd6,  // hold x*b2, multiply y by a2
    CMD_UPD2  = 3'd7   // write delay two
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not taken this cycle
  } dp_status_t;

endpackage

// File: hdl/biquad_ctrl.sv
// ----------------------------------------------------------------------------
// Biquad controller
// Sequences the shared multiplier through the five products of one item.
// ----------------------------------------------------------------------------
module biquad_ctrl
  import biquad_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_SUM1  = 6'b000100,
    S_UPD1  = 6'b001000,
    S_SUM2  = 6'b010000,
    S_UPD2  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_CLEAR) begin
            cmd_o.op = CMD_CLEAR;
          end else begin
            cmd_o.op = CMD_LOAD;
            state_d  = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        // hold until the result register can take the new sample
        if (!status_i.out_busy) begin
          cmd_o.op = CMD_ROUND;
          state_d  = S_SUM1;
        end
      end
      S_SUM1: begin
        cmd_o.op = CMD_SUM1;
        state_d  = S_UPD1;
      end
      S_UPD1: begin
        cmd_o.op = CMD_UPD1;
        state_d  = S_SUM2;
      end
      S_SUM2: begin
        cmd_o.op = CMD_SUM2;
        state_d  = S_UPD2;
      end
      S_UPD2: begin
        cmd_o.op = CMD_UPD2;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/biquad_dp.sv
// ----------------------------------------------------------------------------
// Biquad datapath
// Coefficient registers, shared multiplier, state words and result register.
// ----------------------------------------------------------------------------
module biquad_dp
  import biquad_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COEF_W-1:0]             cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int unsigned PW = SAMPLE_BITS + COEF_W;
  localparam int unsigned AW = ((PW > ST_W) ? PW : ST_W) + 2;

  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] YMAX = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] YMIN = -YMAX - AW'(1);
  localparam logic signed [AW-1:0] SMAX = AW'(ST_MAX);
  localparam logic signed [AW-1:0] SMIN = AW'(ST_MIN);

  logic signed [COEF_W-1:0]      b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [ST_W-1:0]        d1_q, d2_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, out_q;
  logic                          out_valid_q;
  logic signed [PW-1:0]          p_q, prod;
  logic signed [AW-1:0]          t_q;

  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [COEF_W-1:0]      mul_b;
  logic signed [AW-1:0]          acc, acc_sh, diff;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [ST_W-1:0]        d_sat;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = x_q;
    mul_b = b1_q;
    case (cmd_i.op)
      CMD_LOAD: begin
        mul_a = sample_in_i;
        mul_b = b0_q;
      end
      CMD_ROUND: begin
        mul_a = x_q;
        mul_b = b1_q;
      end
      CMD_SUM1: begin
        mul_a = y_q;
        mul_b = a1_q;
      end
      CMD_UPD1: begin
        mul_a = x_q;
        mul_b = b2_q;
      end
      CMD_SUM2: begin
        mul_a = y_q;
        mul_b = a2_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = b1_q;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Output: round to nearest, ties up, then clamp to the sample range
  always_comb begin
    acc    = AW'(p_q) + AW'(d1_q) + HALF;
    acc_sh = acc >>> COEF_FRAC_BITS;
    if (acc_sh > YMAX) begin
      y_sat = YMAX[SAMPLE_BITS-1:0];
    end else if (acc_sh < YMIN) begin
      y_sat = YMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = acc_sh[SAMPLE_BITS-1:0];
    end
  end

  // State update: subtract feedback product, clamp to the state width
  always_comb begin
    diff = t_q - AW'(p_q);
    if (diff > SMAX) begin
      d_sat = ST_MAX;
    end else if (diff < SMIN) begin
      d_sat = ST_MIN;
    end else begin
      d_sat = diff[ST_W-1:0];
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        x_q <= sample_in_i;
        p_q <= prod;
      end
      CMD_ROUND: begin
        y_q   <= y_sat;
        out_q <= y_sat;
        p_q   <= prod;
      end
      CMD_SUM1: begin
        t_q <= AW'(p_q) + AW'(d2_q);
        p_q <= prod;
      end
      CMD_UPD1: begin
        p_q <= prod;
      end
      CMD_SUM2: begin
        t_q <= AW'(p_q);
        p_q <= prod;
      end
      default: begin
      end
    endcase
  end

  // State words, coefficients and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q        <= COEF_W'(1) << COEF_FRAC_BITS;
      b1_q        <= '0;
      b2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_B0:  b0_q <= cfg_data_i;
          REG_B1:  b1_q <= cfg_data_i;
          REG_B2:  b2_q <= cfg_data_i;
          REG_A1:  a1_q <= cfg_data_i;
          REG_A2:  a2_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        CMD_CLEAR: begin
          d1_q <= '0;
          d2_q <= '0;
        end
        CMD_UPD1: d1_q <= d_sat;
        CMD_UPD2: d2_q <= d_sat;
        default: begin
        end
      endcase
      if (cmd_i.op == CMD_ROUND) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter, transposed direct form II
// Second-order fixed-point filter with one shared multiplier.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, op_i, sample_in_i | sink
//  out     | out_valid_o, out_ready_i, sample_out_o    | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | sink
//          | cfg_data_i                                |
//
//  A filter item forms x*b0 in its accept cycle, then four more products
//  follow on the single multiplier, one per cycle unless the rounding step
//  stalls, and a last step writes delay two. A clear item gives no result.
//  Reset sets b0 to 1.0, the other coefficients and both states to zero.
//  A result not yet taken stalls the next item at its rounding step; the
//  result register frees as soon as out_ready_i is seen.
// ----------------------------------------------------------------------------
module biquad_iir_filter
  import biquad_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  // coefficient writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COEF_W-1:0]             cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Coefficient writes go straight to the registers, always take them
  assign cfg_ready_o = 1'b1;

  biquad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  biquad_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule
